// ===== rtl/slle_pkg.sv =====
package slle_pkg;

  localparam int SLOTS_DEFAULT = 1024;
  localparam int POS_W         = 10;
  localparam int VALUE_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int LENGTH_W      = 10;
  localparam int SLOT_W        = 10;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_POS = 2'd1,
    STATUS_NO_FREE = 2'd2
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [LENGTH_W-1:0]   length;
    logic [SLOT_W-1:0]     slot;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_I_FREE,
    ST_I_NEXT,
    ST_WALK,
    ST_HOP,
    ST_SPLICE,
    ST_I_LINK,
    ST_D_TGT,
    ST_D_NEXT,
    ST_D_FREE,
    ST_D_PUSH,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/slle_ram.sv =====
module slle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/static_linked_list_engine.sv =====
// Cursor-linked list held in a slot array of SLOTS entries. Slot 0 heads the
// free list and slot SLOTS-1 heads the data list, so at most SLOTS-2 elements
// fit. Each request beat (insert before or delete at a 1-based position)
// yields one response beat with status, new length and the slot used. After
// reset the block initializes every slot of the link memory and stalls
// requests meanwhile. A request with a bad position is answered in the cycle
// after it is accepted; an insert into a full list goes from the free list
// read straight to the output state; a valid insert or delete walks the links,
// one link memory read per hop. A new request is taken only while idle.
module static_linked_list_engine #(
  parameter int SLOTS = slle_pkg::SLOTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  slle_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output slle_pkg::rsp_t rsp
);

  import slle_pkg::*;

  localparam int AW = $clog2(SLOTS);
  localparam int VW = ((POS_W > AW) ? POS_W : AW) + 1;
  localparam logic [AW-1:0] HEAD     = AW'(SLOTS - 1);
  localparam logic [AW-1:0] FREE_END = AW'(SLOTS - 2);

  state_t state, state_next;

  logic [AW-1:0]      clr;
  logic [AW-1:0]      count;
  logic [AW-1:0]      cur;
  logic [AW-1:0]      hops;
  logic [AW-1:0]      slot_j;
  logic               is_del;
  logic [VALUE_W-1:0] value;
  status_t            res_status;
  logic [AW-1:0]      res_slot;

  logic               link_we;
  logic [AW-1:0]      link_waddr;
  logic [AW-1:0]      link_wdata;
  logic [AW-1:0]      link_raddr;
  logic [AW-1:0]      link_rdata;
  logic               data_we;

  logic               rsp_free;
  logic               req_accept;
  logic [VW-1:0]      pos_ext;
  logic [VW-1:0]      cnt_ext;
  logic               pos_ok;
  logic               rsp_load;
  logic               rsp_load_err;

  slle_ram #(
    .WIDTH (AW),
    .DEPTH (SLOTS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  slle_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (SLOTS)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_we),
    .waddr (slot_j),
    .wdata (value),
    .raddr (AW'(0)),
    .rdata ()
  );

  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign req_stall  = !((state == ST_IDLE) && rsp_free);
  assign req_accept = req_valid && !req_stall;

  assign pos_ext = VW'(req.position);
  assign cnt_ext = VW'(count);

  always_comb begin
    if (req.op == OP_INSERT) begin
      pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + VW'(1));
    end else begin
      pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext);
    end
  end

  always_comb begin
    state_next   = state;
    link_we      = 1'b0;
    link_waddr   = '0;
    link_wdata   = '0;
    link_raddr   = '0;
    data_we      = 1'b0;
    rsp_load     = 1'b0;
    rsp_load_err = 1'b0;
    case (state)
      ST_CLEAR: begin
        link_we    = 1'b1;
        link_waddr = clr;
        link_wdata = (clr < FREE_END) ? clr + AW'(1) : '0;
        if (clr == HEAD) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_accept) begin
          if (!pos_ok) begin
            rsp_load_err = 1'b1;
          end else if (req.op == OP_INSERT) begin
            link_raddr = '0;
            state_next = ST_I_FREE;
          end else begin
            state_next = ST_WALK;
          end
        end
      end
      ST_I_FREE: begin
        link_raddr = link_rdata;
        if (link_rdata == '0) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_I_NEXT;
        end
      end
      ST_I_NEXT: begin
        link_we    = 1'b1;
        link_waddr = '0;
        link_wdata = link_rdata;
        data_we    = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        link_raddr = cur;
        if (hops == '0) begin
          state_next = is_del ? ST_D_TGT : ST_SPLICE;
        end else begin
          state_next = ST_HOP;
        end
      end
      ST_HOP: begin
        link_raddr = link_rdata;
        if (hops == AW'(1)) begin
          state_next = is_del ? ST_D_TGT : ST_SPLICE;
        end
      end
      ST_SPLICE: begin
        link_we    = 1'b1;
        link_waddr = slot_j;
        link_wdata = link_rdata;
        state_next = ST_I_LINK;
      end
      ST_I_LINK: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = slot_j;
        state_next = ST_OUT;
      end
      ST_D_TGT: begin
        link_raddr = link_rdata;
        state_next = ST_D_NEXT;
      end
      ST_D_NEXT: begin
        link_we    = 1'b1;
        link_waddr = cur;
        link_wdata = link_rdata;
        link_raddr = '0;
        state_next = ST_D_FREE;
      end
      ST_D_FREE: begin
        link_we    = 1'b1;
        link_waddr = slot_j;
        link_wdata = link_rdata;
        state_next = ST_D_PUSH;
      end
      ST_D_PUSH: begin
        link_we    = 1'b1;
        link_waddr = '0;
        link_wdata = slot_j;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (rsp_free) begin
          rsp_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr   <= '0;
      count <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr <= clr + AW'(1);
      end
      if (state == ST_I_LINK) begin
        count <= count + AW'(1);
      end else if (state == ST_D_PUSH) begin
        count <= count - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        is_del     <= (req.op == OP_DELETE);
        value      <= req.value;
        cur        <= HEAD;
        hops       <= AW'(pos_ext - VW'(1));
        res_status <= STATUS_OK;
        res_slot   <= '0;
      end
      ST_I_FREE: begin
        slot_j <= link_rdata;
        if (link_rdata == '0) begin
          res_status <= STATUS_NO_FREE;
        end
      end
      ST_HOP: begin
        cur  <= link_rdata;
        hops <= hops - AW'(1);
      end
      ST_D_TGT: begin
        slot_j <= link_rdata;
      end
      ST_I_LINK, ST_D_PUSH: begin
        res_slot <= slot_j;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load || rsp_load_err) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load_err) begin
      rsp.status <= STATUS_BAD_POS;
      rsp.length <= LENGTH_W'(count);
      rsp.slot   <= '0;
    end else if (rsp_load) begin
      rsp.status <= res_status;
      rsp.length <= LENGTH_W'(count);
      rsp.slot   <= SLOT_W'(res_slot);
    end
  end

endmodule
